/* rtl/core/s256c_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s256c_pkg: shared types and constants for the four-lane sha-256 core
// Round constants, sha-256 helper functions and the command codes.
// ---------------------------------------------------------------------------
package s256c_pkg;

    localparam int IO_LANES      = 4;
    localparam int DEFAULT_LANES = 4;
    localparam int WORD_W        = 32;

    typedef enum logic {
        CMD_CHAIN = 1'b0,
        CMD_MSG   = 1'b1
    } t_cmd;

    typedef logic [WORD_W-1:0] t_word;

    function automatic t_word round_k(input logic [5:0] t);
        t_word k;
        unique case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

/* rtl/core/sha256_compress_four_lane_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha256_compress_four_lane_core: four-lane sha-256 compression
// Word loads are taken one per cycle while idle. Message word 15 starts a
// memory sweep (LOAD) into the working registers, then 64 rounds (one per
// cycle), then eight read-add-write steps (FOLD, EMIT), one transaction out
// each. Input stalls from word 15 until the eighth transaction is emitted;
// EMIT waits while the output is stalled.
// Synchronous active-low reset clears the sequencer and output valid only.
// ---------------------------------------------------------------------------
module sha256_compress_four_lane_core #(
    parameter int LANES = s256c_pkg::DEFAULT_LANES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [3:0]  i_word_index,
    input  logic [31:0] i_lane0_word,
    input  logic [31:0] i_lane1_word,
    input  logic [31:0] i_lane2_word,
    input  logic [31:0] i_lane3_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_hash_index,
    output logic [31:0] o_lane0_hash,
    output logic [31:0] o_lane1_hash,
    output logic [31:0] o_lane2_hash,
    output logic [31:0] o_lane3_hash,
    output logic        o_last
);
    import s256c_pkg::*;

    logic       sched_we, chain_we, chain_in_sel, chain_re, sched_re;
    logic       load_var, round_en, expand, add_var, emit, out_free;
    logic [3:0] sched_waddr, sched_raddr;
    logic [2:0] chain_waddr, chain_raddr;
    logic [5:0] round_t;
    t_word      in_w  [LANES];
    t_word      sum_w [LANES];
    t_word      r_hash [IO_LANES];
    logic       r_valid;
    logic [2:0] r_idx;
    logic       r_last;

    assign out_free = !r_valid || !i_stall;

    s256c_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid     (i_valid),
        .i_command,
        .i_word_index,
        .o_in_stall     (o_stall),
        .i_out_free     (out_free),
        .o_sched_we     (sched_we),
        .o_sched_waddr  (sched_waddr),
        .o_chain_we     (chain_we),
        .o_chain_waddr  (chain_waddr),
        .o_chain_in_sel (chain_in_sel),
        .o_chain_re     (chain_re),
        .o_chain_raddr  (chain_raddr),
        .o_sched_re     (sched_re),
        .o_sched_raddr  (sched_raddr),
        .o_load_var     (load_var),
        .o_round        (round_en),
        .o_expand       (expand),
        .o_round_t      (round_t),
        .o_add_var      (add_var),
        .o_emit         (emit)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        always_comb begin
            unique case (l)
                0:       in_w[l] = i_lane0_word;
                1:       in_w[l] = i_lane1_word;
                2:       in_w[l] = i_lane2_word;
                3:       in_w[l] = i_lane3_word;
                default: in_w[l] = '0;
            endcase
        end
        s256c_lane u_lane (
            .i_clk,
            .i_sched_we    (sched_we),
            .i_sched_waddr (sched_waddr),
            .i_sched_wdata (in_w[l]),
            .i_chain_we    (chain_we),
            .i_chain_waddr (chain_waddr),
            .i_chain_wdata (chain_in_sel ? sum_w[l] : in_w[l]),
            .i_chain_re    (chain_re),
            .i_chain_raddr (chain_raddr),
            .i_sched_re    (sched_re),
            .i_sched_raddr (sched_raddr),
            .i_load_var    (load_var),
            .i_round       (round_en),
            .i_expand      (expand),
            .i_round_t     (round_t),
            .i_add_var     (add_var),
            .o_sum         (sum_w[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_idx  <= chain_waddr;
            r_last <= (chain_waddr == 3'd7);
            for (int l = 0; l < IO_LANES; l++) begin
                r_hash[l] <= (l < LANES) ? sum_w[l] : '0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_hash_index = r_idx;
    assign o_lane0_hash = r_hash[0];
    assign o_lane1_hash = r_hash[1];
    assign o_lane2_hash = r_hash[2];
    assign o_lane3_hash = r_hash[3];
    assign o_last       = r_last;

endmodule

/* rtl/core/s256c_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s256c_lane: one lane of the compression datapath
// Holds the 16-word schedule memory and the chaining-word memory of one lane,
// runs one round per step and folds the working variables back at the end.
// ---------------------------------------------------------------------------
module s256c_lane (
    input  logic                   i_clk,
    input  logic                   i_sched_we,
    input  logic [3:0]             i_sched_waddr,
    input  s256c_pkg::t_word       i_sched_wdata,
    input  logic                   i_chain_we,
    input  logic [2:0]             i_chain_waddr,
    input  s256c_pkg::t_word       i_chain_wdata,
    input  logic                   i_chain_re,
    input  logic [2:0]             i_chain_raddr,
    input  logic                   i_sched_re,
    input  logic [3:0]             i_sched_raddr,
    input  logic                   i_load_var,
    input  logic                   i_round,
    input  logic                   i_expand,
    input  logic [5:0]             i_round_t,
    input  logic                   i_add_var,
    output s256c_pkg::t_word       o_sum
);
    import s256c_pkg::*;

    // schedule memory feeds the window before the rounds and takes the
    // expanded words back during them, so untouched words carry over
    t_word r_sched [16];
    t_word r_chain [8];
    t_word r_sched_rd;
    t_word r_chain_rd;
    t_word r_var [8];
    t_word n_var [8];
    t_word w_t;
    t_word t1;
    t_word t2;

    // the four schedule taps come from registers shadowing the window
    t_word r_win [16];

    always_ff @(posedge i_clk) begin
        if (i_sched_we) begin
            r_sched[i_sched_waddr] <= i_round ? w_t : i_sched_wdata;
        end
        if (i_sched_re) begin
            r_sched_rd <= r_sched[i_sched_raddr];
        end
        if (i_chain_we) begin
            r_chain[i_chain_waddr] <= i_chain_wdata;
        end
        if (i_chain_re) begin
            r_chain_rd <= r_chain[i_chain_raddr];
        end
    end

    always_comb begin
        if (i_expand) begin
            w_t = sig1(r_win[14]) + r_win[9] + sig0(r_win[1]) + r_win[0];
        end else begin
            w_t = r_win[0];
        end
        t1 = r_var[7] + bsig1(r_var[4]) + ((r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]))
             + round_k(i_round_t) + w_t;
        t2 = bsig0(r_var[0]) + ((r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2])
             ^ (r_var[1] & r_var[2]));
        n_var[0] = t1 + t2;
        n_var[1] = r_var[0];
        n_var[2] = r_var[1];
        n_var[3] = r_var[2];
        n_var[4] = r_var[3] + t1;
        n_var[5] = r_var[4];
        n_var[6] = r_var[5];
        n_var[7] = r_var[6];
    end

    always_ff @(posedge i_clk) begin
        if (i_load_var) begin
            // shift chaining words in, a first
            for (int j = 0; j < 7; j++) begin
                r_var[j] <= r_var[j+1];
            end
            r_var[7] <= r_chain_rd;
        end else if (i_round) begin
            r_var <= n_var;
        end else if (i_add_var) begin
            for (int j = 0; j < 7; j++) begin
                r_var[j] <= r_var[j+1];
            end
            r_var[7] <= r_var[0];
        end
        if (i_load_var) begin
            // window fills from the schedule memory read in the same sweep
            for (int j = 0; j < 15; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[15] <= r_sched_rd;
        end else if (i_round) begin
            for (int j = 0; j < 15; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[15] <= w_t;
        end
    end

    assign o_sum = r_chain_rd + r_var[0];

endmodule

/* rtl/core/s256c_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s256c_ctrl: sequencer of the compression core
// Loads chaining and schedule words, steps 64 rounds and writes back the
// eight chaining words while handing them to the output register.
// ---------------------------------------------------------------------------
module s256c_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_command,
    input  logic [3:0]  i_word_index,
    output logic        o_in_stall,
    input  logic        i_out_free,
    output logic        o_sched_we,
    output logic [3:0]  o_sched_waddr,
    output logic        o_chain_we,
    output logic [2:0]  o_chain_waddr,
    output logic        o_chain_in_sel,
    output logic        o_chain_re,
    output logic [2:0]  o_chain_raddr,
    output logic        o_sched_re,
    output logic [3:0]  o_sched_raddr,
    output logic        o_load_var,
    output logic        o_round,
    output logic        o_expand,
    output logic [5:0]  o_round_t,
    output logic        o_add_var,
    output logic        o_emit
);
    import s256c_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic [5:0]  r_t, n_t;
    logic        acc;

    assign o_in_stall = (r_state != ST_IDLE);
    assign acc        = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_t            = r_t;
        o_sched_we     = 1'b0;
        o_sched_waddr  = i_word_index;
        o_chain_we     = 1'b0;
        o_chain_waddr  = i_word_index[2:0];
        o_chain_in_sel = 1'b0;
        o_chain_re     = 1'b0;
        o_chain_raddr  = r_cnt[2:0];
        o_sched_re     = 1'b0;
        o_sched_raddr  = r_cnt[3:0];
        o_load_var     = 1'b0;
        o_round        = 1'b0;
        o_expand       = (r_t[5:4] != 2'd0);
        o_round_t      = r_t;
        o_add_var      = 1'b0;
        o_emit         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (t_cmd'(i_command) == CMD_CHAIN) begin
                        o_chain_we = !i_word_index[3];
                    end else begin
                        o_sched_we = 1'b1;
                        if (i_word_index == 4'd15) begin
                            n_state = ST_LOAD;
                            n_cnt   = '0;
                        end
                    end
                end
            end
            ST_LOAD: begin
                // read address r_cnt; the registered read data is loaded at cnt 1..16
                o_chain_re = 1'b1;
                o_sched_re = 1'b1;
                o_load_var = (r_cnt != 5'd0);
                o_chain_raddr = r_cnt[2:0];
                if (r_cnt != 5'd0 && r_cnt <= 5'd8) begin
                    o_load_var = 1'b1;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    n_state = ST_ROUND;
                    n_t     = '0;
                end
            end
            ST_ROUND: begin
                o_round = 1'b1;
                // expanded words go back in place for the next block
                o_sched_we    = o_expand;
                o_sched_waddr = r_t[3:0];
                n_t     = r_t + 6'd1;
                if (r_t == 6'd63) begin
                    n_state = ST_FOLD;
                    n_cnt   = '0;
                end
            end
            ST_FOLD: begin
                o_chain_re    = 1'b1;
                o_chain_raddr = r_cnt[2:0];
                n_state       = ST_EMIT;
            end
            default: begin
                // chain word r_cnt is read, add working var, write back, emit
                if (i_out_free) begin
                    o_chain_we     = 1'b1;
                    o_chain_waddr  = r_cnt[2:0];
                    o_chain_in_sel = 1'b1;
                    o_add_var      = 1'b1;
                    o_emit         = 1'b1;
                    n_cnt          = r_cnt + 5'd1;
                    if (r_cnt[2:0] == 3'd7) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_FOLD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_t     <= n_t;
        end
    end

endmodule

/* rtl/core/s256c_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s256c_checker: port-level checks for the compression core
// Watches handshakes and result ordering on the top-level ports.
// ---------------------------------------------------------------------------
module s256c_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_stall,
    input logic [2:0] o_hash_index,
    input logic       o_last
);
    // last marks the eighth word
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_hash_index == 3'd7))) else $error("last mismatch");

    // after a non-last transaction is taken, a following valid index is not zero
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) ##1 o_valid |-> o_hash_index != 3'd0)
        else $error("index order");

    // no input taken while results of a block are pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_stall) else $error("input during output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hash_index)))
        else $error("stalled transaction changed");
endmodule

bind sha256_compress_four_lane_core s256c_checker u_chk (.*);
